[design/nsp_pkg.sv]
// ----------------------------------------------------------------------------
// nsp_pkg: shared definitions for the nearest screen lookup
// widths, register indexes and lane types used by the interfaces and the core
// ----------------------------------------------------------------------------
package nsp_pkg;

	localparam int RECT_REGS       = 4;
	localparam int MAX_SCREENS_DEF = 4;

	localparam int COORD_W = 16;
	localparam int EDGE_W  = COORD_W + 2;
	localparam int DELTA_W = COORD_W + 1;
	localparam int DIST_W  = 18;
	localparam int INDEX_W = 2;
	localparam int COUNT_W = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_ZERO    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_ONE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_TWO     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_THREE   = 3'd4;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [EDGE_W-1:0]  edge_t;
	typedef logic [DELTA_W-1:0]        delta_t;
	typedef logic [DIST_W-1:0]         dist_t;
	typedef logic [INDEX_W-1:0]        index_t;

	// rectangle edges of one lane after the first stage
	typedef struct packed {
		edge_t left;
		edge_t right;
		edge_t top;
		edge_t bottom;
		logic  invalid;
	} lane_edges_t;

	// per-axis distances of one lane after the second stage
	typedef struct packed {
		delta_t dx;
		delta_t dy;
	} lane_delta_t;

endpackage

[design/nsp_if.sv]
// ----------------------------------------------------------------------------
// nsp_if: valid/ready channels of the nearest screen lookup
// query point channel and result channel, each with source and sink modports
// ----------------------------------------------------------------------------
interface nsp_point_if;
	import nsp_pkg::*;

	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface nsp_result_if;
	import nsp_pkg::*;

	logic   valid;
	logic   ready;
	index_t screen_index;
	dist_t  min_distance;

	modport source (output valid, output screen_index, output min_distance, input ready);
	modport sink   (input valid, input screen_index, input min_distance, output ready);
endinterface

[design/nearest_screen_of_point.sv]
// Four register stages (edges, axis deltas, per-screen sum, lowest-index minimum)
// each advance on their own valid bit. Throughput: one point per cycle while the
// result side is ready; a stalled result side holds the full stages back.
// Reset clears the screen count, the rectangles and every stage valid bit.
// ----------------------------------------------------------------------------
// nearest_screen_of_point: nearest configured screen to a query point
// manhattan distance to each rectangle, smallest wins, ties to lowest index
// ----------------------------------------------------------------------------
module nearest_screen_of_point #(
	parameter int MAX_SCREENS = nsp_pkg::MAX_SCREENS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [nsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nsp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	nsp_point_if.sink                        point,
	nsp_result_if.source                     result
);
	import nsp_pkg::*;

	localparam int NUM_LANES = (MAX_SCREENS < RECT_REGS) ? MAX_SCREENS : RECT_REGS;

	// configuration
	logic [COUNT_W-1:0]    screen_count_q;
	logic [CFG_DATA_W-1:0] rect_q [NUM_LANES];
	logic [COUNT_W-1:0]    eff_count;
	logic [NUM_LANES-1:0]  lane_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_count_q <= '0;
			for (int l = 0; l < NUM_LANES; l++) begin
				rect_q[l] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_SCREEN_COUNT) begin
				screen_count_q <= cfg_wdata[COUNT_W-1:0];
			end
			for (int l = 0; l < NUM_LANES; l++) begin
				if (cfg_index == REG_RECT_ZERO + CFG_IDX_W'(l)) begin
					rect_q[l] <= cfg_wdata;
				end
			end
		end
	end

	assign eff_count = (screen_count_q > COUNT_W'(NUM_LANES)) ? COUNT_W'(NUM_LANES)
	                                                          : screen_count_q;

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			lane_en[l] = COUNT_W'(l) < eff_count;
		end
	end

	// stage advance
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4 = !v_s4 || result.ready;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign point.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= point.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
			if (adv_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// stage 1: rectangle edges, right and bottom inclusive
	coord_t      px_s1, py_s1;
	lane_edges_t edges_s1 [NUM_LANES];

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			px_s1 <= point.point_x;
			py_s1 <= point.point_y;
			for (int l = 0; l < NUM_LANES; l++) begin
				edges_s1[l].left    <= EDGE_W'(signed'(rect_q[l][15:0]));
				edges_s1[l].top     <= EDGE_W'(signed'(rect_q[l][31:16]));
				edges_s1[l].right   <= EDGE_W'(signed'(rect_q[l][15:0]))
				                     + edge_t'({2'b00, rect_q[l][47:32]}) - edge_t'(1);
				edges_s1[l].bottom  <= EDGE_W'(signed'(rect_q[l][31:16]))
				                     + edge_t'({2'b00, rect_q[l][63:48]}) - edge_t'(1);
				edges_s1[l].invalid <= (rect_q[l][47:32] == '0) || (rect_q[l][63:48] == '0);
			end
		end
	end

	// stage 2: distance along each axis
	edge_t       pxe_s1, pye_s1;
	delta_t      abs_x, abs_y;
	lane_delta_t delta_s2 [NUM_LANES];

	assign pxe_s1 = EDGE_W'(px_s1);
	assign pye_s1 = EDGE_W'(py_s1);
	assign abs_x  = px_s1[COORD_W-1] ? DELTA_W'(-pxe_s1) : DELTA_W'(pxe_s1);
	assign abs_y  = py_s1[COORD_W-1] ? DELTA_W'(-pye_s1) : DELTA_W'(pye_s1);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				if (edges_s1[l].invalid) begin
					delta_s2[l].dx <= abs_x;
				end else if (pxe_s1 < edges_s1[l].left) begin
					delta_s2[l].dx <= DELTA_W'(edges_s1[l].left - pxe_s1);
				end else if (pxe_s1 > edges_s1[l].right) begin
					delta_s2[l].dx <= DELTA_W'(pxe_s1 - edges_s1[l].right);
				end else begin
					delta_s2[l].dx <= '0;
				end
				if (edges_s1[l].invalid) begin
					delta_s2[l].dy <= abs_y;
				end else if (pye_s1 < edges_s1[l].top) begin
					delta_s2[l].dy <= DELTA_W'(edges_s1[l].top - pye_s1);
				end else if (pye_s1 > edges_s1[l].bottom) begin
					delta_s2[l].dy <= DELTA_W'(pye_s1 - edges_s1[l].bottom);
				end else begin
					delta_s2[l].dy <= '0;
				end
			end
		end
	end

	// stage 3: manhattan distance per screen
	dist_t dist_s3 [NUM_LANES];

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				dist_s3[l] <= DIST_W'(delta_s2[l].dx) + DIST_W'(delta_s2[l].dy);
			end
		end
	end

	// stage 4: first screen at minimal distance, zero result with no screens
	dist_t  best_dist;
	index_t best_idx;
	dist_t  dist_s4;
	index_t idx_s4;

	always_comb begin
		best_dist = lane_en[0] ? dist_s3[0] : '0;
		best_idx  = '0;
		for (int l = 1; l < NUM_LANES; l++) begin
			if (lane_en[l] && dist_s3[l] < best_dist) begin
				best_dist = dist_s3[l];
				best_idx  = INDEX_W'(l);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			dist_s4 <= best_dist;
			idx_s4  <= best_idx;
		end
	end

	assign result.valid        = v_s4;
	assign result.screen_index = idx_s4;
	assign result.min_distance = dist_s4;

`ifndef SYNTHESIS
	// a free output stage always lets a point in
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		result.ready |-> point.ready)
		else $error("point channel stalled while result side is ready");

	// no screens in use gives index zero and distance zero
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && screen_count_q == '0) |->
			(result.screen_index == '0 && result.min_distance == '0))
		else $error("non-zero result with no screens");

	// the chosen screen is one that is in use
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && eff_count != '0) |->
			(COUNT_W'(result.screen_index) < eff_count))
		else $error("screen index beyond screen count");
`endif

endmodule

[tb/nearest_screen_of_point_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_screen_of_point_test: self-checking bench for the nearest screen lookup
// a directed table of points and register writes, then randomised screen
// settings with bursty point traffic and a stalling result side; every result
// is checked against the table's expected value or an in-bench predictor
// ----------------------------------------------------------------------------
module nearest_screen_of_point_test;
	import nsp_pkg::*;

	localparam int NUM_PHASES       = 8;
	localparam int POINTS_PER_PHASE = 200;
	localparam int SETTLE_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int HOLDOFF_AFTER    = 400;
	localparam int HOLDOFF_CYCLES   = 120;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	typedef struct packed {
		index_t screen;
		dist_t  distance;
	} nearest_t;

	typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [CFG_IDX_W-1:0]    reg_index;
		logic [CFG_DATA_W-1:0]   reg_data;
		coord_t                  px;
		coord_t                  py;
		logic                    checked;
		nearest_t                want;
	} stim_row_t;

	// rectangle packing: {height, width, y, x}
	localparam stim_row_t DIRECTED_ROWS [32] = '{
		// no screens after reset
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 0, 0, 1'b1, '{2'd0, 18'd0}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, -32768, -32768, 1'b1, '{2'd0, 18'd0}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 32767, 32767, 1'b1, '{2'd0, 18'd0}},
		// one screen, still the zero rectangle from reset
		'{ROW_WRITE, REG_SCREEN_COUNT, 64'd1, 0, 0, 1'b0, '{2'd0, 18'd0}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, -32768, -32768, 1'b1, '{2'd0, 18'd65536}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 32767, -32768, 1'b1, '{2'd0, 18'd65535}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 3, -4, 1'b1, '{2'd0, 18'd7}},
		// x -10, y -20, 30 by 40: right and bottom both 19
		'{ROW_WRITE, REG_RECT_ZERO, 64'h0028_001E_FFEC_FFF6, 0, 0, 1'b0, '{2'd0, 18'd0}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 0, 0, 1'b1, '{2'd0, 18'd0}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 19, 19, 1'b1, '{2'd0, 18'd0}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 20, 19, 1'b1, '{2'd0, 18'd1}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, -15, 5, 1'b1, '{2'd0, 18'd5}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, -12, -25, 1'b1, '{2'd0, 18'd7}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 25, 30, 1'b1, '{2'd0, 18'd17}},
		// identical second screen: tie goes to the lower index
		'{ROW_WRITE, REG_RECT_ONE, 64'h0028_001E_FFEC_FFF6, 0, 0, 1'b0, '{2'd0, 18'd0}},
		'{ROW_WRITE, REG_SCREEN_COUNT, 64'd2, 0, 0, 1'b0, '{2'd0, 18'd0}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 100, 100, 1'b1, '{2'd0, 18'd162}},
		// 1 by 1 at (100,100) and a full-size screen at the far corner
		'{ROW_WRITE, REG_RECT_TWO, 64'h0001_0001_0064_0064, 0, 0, 1'b0, '{2'd0, 18'd0}},
		'{ROW_WRITE, REG_RECT_THREE, 64'hFFFF_FFFF_7FFF_7FFF, 0, 0, 1'b0, '{2'd0, 18'd0}},
		// count above the number of rectangles
		'{ROW_WRITE, REG_SCREEN_COUNT, 64'd7, 0, 0, 1'b0, '{2'd0, 18'd0}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 100, 100, 1'b1, '{2'd2, 18'd0}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 32767, 32767, 1'b1, '{2'd3, 18'd0}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, -32768, -32768, 1'b0, '{2'd0, 18'd0}},
		'{ROW_WRITE, REG_SCREEN_COUNT, 64'd3, 0, 0, 1'b0, '{2'd0, 18'd0}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 32767, 32767, 1'b0, '{2'd0, 18'd0}},
		// writes to unused indexes must leave everything alone
		'{ROW_WRITE, REG_UNUSED_LO, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 1'b0, '{2'd0, 18'd0}},
		'{ROW_WRITE, REG_UNUSED_HI, 64'd0, 0, 0, 1'b0, '{2'd0, 18'd0}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 101, 100, 1'b1, '{2'd2, 18'd1}},
		// zero-width screen
		'{ROW_WRITE, REG_RECT_TWO, 64'h0009_0000_FFFB_0005, 0, 0, 1'b0, '{2'd0, 18'd0}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 40, -30, 1'b0, '{2'd0, 18'd0}},
		'{ROW_WRITE, REG_SCREEN_COUNT, 64'd0, 0, 0, 1'b0, '{2'd0, 18'd0}},
		'{ROW_POINT, REG_SCREEN_COUNT, 64'd0, 1234, -4321, 1'b1, '{2'd0, 18'd0}}
	};

	localparam coord_t COORD_EXTREMES [4] = '{-32768, -1, 0, 32767};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	nsp_point_if  point_ch ();
	nsp_result_if result_ch ();

	nearest_screen_of_point dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.point     (point_ch),
		.result    (result_ch)
	);

	// mirror of the configuration as the block should hold it
	logic [COUNT_W-1:0]    screens_in_use;
	logic [CFG_DATA_W-1:0] screen_rect [RECT_REGS];

	nearest_t nearest_expected [$];
	int       errors;
	int       points_sent;
	int       results_checked;
	int       reg_writes;
	int       burst_left;
	int       idle_cycles;
	bit       holdoff_done;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int screens_active();
		int n;
		n = int'(screens_in_use);
		if (n > RECT_REGS)
			n = RECT_REGS;
		if (n > MAX_SCREENS_DEF)
			n = MAX_SCREENS_DEF;
		return n;
	endfunction

	function automatic int rect_manhattan(logic [CFG_DATA_W-1:0] r, int px, int py);
		int left, top, w, h, right, bottom, dx, dy;
		left = int'(coord_t'(r[15:0]));
		top  = int'(coord_t'(r[31:16]));
		w    = int'(r[47:32]);
		h    = int'(r[63:48]);
		if (w == 0 || h == 0)
			return (px < 0 ? -px : px) + (py < 0 ? -py : py);
		right  = left + w - 1;
		bottom = top + h - 1;
		dx = (px < left) ? left - px : (px > right) ? px - right : 0;
		dy = (py < top) ? top - py : (py > bottom) ? py - bottom : 0;
		return dx + dy;
	endfunction

	function automatic nearest_t predict_nearest(coord_t px, coord_t py);
		nearest_t best;
		int       d, best_d, n;
		n      = screens_active();
		best   = '0;
		best_d = 0;
		for (int i = 0; i < n; i++) begin
			d = rect_manhattan(screen_rect[i], px, py);
			if (i == 0 || d < best_d) begin
				best_d      = d;
				best.screen = index_t'(i);
			end
		end
		best.distance = dist_t'(best_d);
		return best;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_rect();
		logic [15:0] x, y, w, h;
		x = 16'($urandom_range(0, 4000) - 2000);
		y = 16'($urandom_range(0, 4000) - 2000);
		w = 16'($urandom_range(1, 800));
		h = 16'($urandom_range(1, 800));
		case ($urandom_range(0, 9))
			0: return {$urandom, $urandom};
			1: begin
				if ($urandom_range(0, 1))
					w = '0;
				else
					h = '0;
			end
			2: begin
				x = COORD_EXTREMES[$urandom_range(0, 3)];
				y = COORD_EXTREMES[$urandom_range(0, 3)];
				w = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
				h = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
			end
			default: ;
		endcase
		return {h, w, y, x};
	endfunction

	// single register write, mirror updated at the edge that takes it
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		if (idx == REG_SCREEN_COUNT)
			screens_in_use = data[COUNT_W-1:0];
		else if (idx >= REG_RECT_ZERO && idx <= REG_RECT_THREE)
			screen_rect[idx - REG_RECT_ZERO] = data;
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// stop offering points and let the pipeline run dry
	task automatic settle_idle();
		@(negedge clk);
		point_ch.valid <= 1'b0;
		while (nearest_expected.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_point(coord_t px, coord_t py, logic checked, nearest_t want);
		@(negedge clk);
		point_ch.valid   <= 1'b1;
		point_ch.point_x <= px;
		point_ch.point_y <= py;
		do
			@(posedge clk);
		while (point_ch.ready !== 1'b1);
		nearest_expected.push_back(checked ? want : predict_nearest(px, py));
		points_sent++;
	endtask

	// bursts of back-to-back points separated by idle gaps
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				point_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
		end
	endtask

	task automatic send_random_point();
		coord_t                px, py;
		int                    n, i, w, h;
		logic [CFG_DATA_W-1:0] r;
		n  = screens_active();
		px = coord_t'($urandom);
		py = coord_t'($urandom);
		case ($urandom_range(0, 9)) inside
			[0:2]: ;
			3: begin
				px = COORD_EXTREMES[$urandom_range(0, 3)];
				py = COORD_EXTREMES[$urandom_range(0, 3)];
			end
			default: begin
				// land on, just inside or just outside a screen in use
				if (n > 0) begin
					i  = $urandom_range(0, n - 1);
					r  = screen_rect[i];
					w  = int'(r[47:32]);
					h  = int'(r[63:48]);
					px = coord_t'(int'(coord_t'(r[15:0])) + $urandom_range(0, w + 8) - 4);
					py = coord_t'(int'(coord_t'(r[31:16])) + $urandom_range(0, h + 8) - 4);
				end
			end
		endcase
		send_point(px, py, 1'b0, '0);
	endtask

	// result side: a changing stall pattern plus one long hold-off
	initial begin : result_ready_driver
		logic [15:0] stall_pattern;
		int          pattern_age;
		int          hold_left;
		result_ch.ready = 1'b0;
		stall_pattern   = '1;
		pattern_age     = 0;
		hold_left       = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (!holdoff_done && points_sent >= HOLDOFF_AFTER) begin
				// sender keeps going, so the pipeline fills and stalls its input
				result_ch.ready <= 1'b0;
				hold_left    = HOLDOFF_CYCLES - 1;
				holdoff_done = 1'b1;
			end else begin
				result_ch.ready <= stall_pattern[pattern_age % 16];
				pattern_age++;
				if (pattern_age == 64) begin
					pattern_age = 0;
					case ($urandom_range(0, 3))
						0: stall_pattern = '1;
						1: stall_pattern = 16'($urandom);
						2: stall_pattern = 16'($urandom | $urandom);
						default: stall_pattern = 16'($urandom & $urandom);
					endcase
					if (stall_pattern == '0)
						stall_pattern[0] = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin : check_result
		nearest_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (nearest_expected.size() == 0) begin
				$display("%0t: result transfer with no point outstanding: index %0d distance %0d",
					$time, result_ch.screen_index, result_ch.min_distance);
				errors++;
			end else begin
				want = nearest_expected.pop_front();
				results_checked++;
				if (result_ch.screen_index !== want.screen) begin
					$display("%0t: screen_index expected %0d, got %0d",
						$time, want.screen, result_ch.screen_index);
					errors++;
				end
				if (result_ch.min_distance !== want.distance) begin
					$display("%0t: min_distance expected %0d, got %0d",
						$time, want.distance, result_ch.min_distance);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((point_ch.valid === 1'b1 && point_ch.ready === 1'b1) ||
			(result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : main_sequence
		stim_row_t row;
		errors          = 0;
		points_sent     = 0;
		results_checked = 0;
		reg_writes      = 0;
		burst_left      = 0;
		idle_cycles     = 0;
		holdoff_done    = 1'b0;
		screens_in_use  = '0;
		for (int i = 0; i < RECT_REGS; i++)
			screen_rect[i] = '0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_wdata        = '0;
		point_ch.valid   = 1'b0;
		point_ch.point_x = '0;
		point_ch.point_y = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_ROWS[r]) begin
			row = DIRECTED_ROWS[r];
			if (row.kind == ROW_WRITE) begin
				settle_idle();
				write_reg(row.reg_index, row.reg_data);
			end else begin
				send_point(row.px, row.py, row.checked, row.want);
				pace_sender();
			end
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			settle_idle();
			if (phase == 1) begin
				// opposite corners, a full-width strip and a zero-width screen
				write_reg(REG_RECT_ZERO, 64'h0001_0001_7FFF_7FFF);
				write_reg(REG_RECT_ONE, 64'h0001_0001_8000_8000);
				write_reg(REG_RECT_TWO, 64'h0001_FFFF_7FFF_8000);
				write_reg(REG_RECT_THREE, 64'hFFFF_0000_0000_0000);
				write_reg(REG_SCREEN_COUNT, 64'd7);
			end else begin
				for (int i = 0; i < RECT_REGS; i++) begin
					if (i > 0 && $urandom_range(0, 5) == 0)
						write_reg(REG_RECT_ZERO + CFG_IDX_W'(i), screen_rect[i - 1]);
					else
						write_reg(REG_RECT_ZERO + CFG_IDX_W'(i), random_rect());
				end
				if ($urandom_range(0, 2) == 0)
					write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
						{$urandom, $urandom});
				if (phase == 0)
					write_reg(REG_SCREEN_COUNT, 64'd0);
				else if ($urandom_range(0, 4) == 0)
					write_reg(REG_SCREEN_COUNT, CFG_DATA_W'($urandom_range(0, 7)));
				else
					write_reg(REG_SCREEN_COUNT, CFG_DATA_W'($urandom_range(1, 4)));
			end
			repeat (POINTS_PER_PHASE) begin
				send_random_point();
				pace_sender();
			end
		end

		settle_idle();
		$display("%0d points sent, %0d results checked, %0d register writes",
			points_sent, results_checked, reg_writes);
		$display("directed table plus %0d random screen settings, long output stall %s",
			NUM_PHASES, holdoff_done ? "done" : "not reached");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
